FILE: rtl/core/scd_pkg.sv
// Shared types and constants for the stereo chorus delay block.
// No dependencies; imported by every module of the block but scd_ram.
package scd_pkg;

    localparam int RING_DEPTH_DEF = 4096;
    localparam int SAMPLE_W       = 32;
    localparam int CFG_IDX_W      = 2;
    localparam int CFG_DATA_W     = 32;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BASE_DELAY = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SEPARATION = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DEPTH      = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PHASE_STEP = 2'd3;

    // one queued frame together with the oscillator phase it is played at
    typedef struct packed {
        logic signed [SAMPLE_W-1:0] send_left;
        logic signed [SAMPLE_W-1:0] send_right;
        logic signed [SAMPLE_W-1:0] dry_left;
        logic signed [SAMPLE_W-1:0] dry_right;
        logic                       frame_last;
        logic [31:0]                phase;
    } frame_t;

    typedef struct packed {
        logic [11:0] base_delay;
        logic [11:0] separation;
        logic [10:0] depth;
    } delay_cfg_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_SUM,
        BK_WRAP,
        BK_RIDX,
        BK_LIDX,
        BK_READ,
        BK_OUT
    } back_state_t;

endpackage

FILE: rtl/core/stereo_chorus_delay_top.sv
// Top level of the stereo chorus delay: configuration registers, front end
// queue and back end. Depends on scd_pkg, scd_front, scd_back.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------------
//   input    | in_valid / in_stall    | send_left, send_right, dry_left,
//            |                        | dry_right, frame_last
//   output   | out_valid / out_stall  | out_left, out_right, end_of_block
//   config   | cfg_we                 | cfg_index, cfg_data
//
// A frame steps through the back-end states in turn: idle, first and second multiply,
// sum, wrap, right index, left index, ring read and output; the wrap state repeats
// once per extra wrap step of the delay and separation modulo RING_DEPTH (none or one at the default depth).
// The front queue holds two frames, so requests are taken while the back end works.
// Reset clears control and counters at once; unwritten ring entries read as
// zero through a fill flag, so no clearing pass is needed.
// A stalled output holds its result while the next frame is processed up to
// the output stage.
module stereo_chorus_delay_top #(
    parameter int RING_DEPTH = scd_pkg::RING_DEPTH_DEF
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  logic signed [31:0]                 send_left,
    input  logic signed [31:0]                 send_right,
    input  logic signed [31:0]                 dry_left,
    input  logic signed [31:0]                 dry_right,
    input  logic                               frame_last,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic signed [31:0]                 out_left,
    output logic signed [31:0]                 out_right,
    output logic                               end_of_block,
    input  logic                               cfg_we,
    input  logic [scd_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [scd_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import scd_pkg::*;

    delay_cfg_t cfg_reg;
    logic [31:0] phase_step_reg;
    logic        q_valid;
    logic        q_pop;
    frame_t      q_item;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg        <= '0;
            phase_step_reg <= 32'd0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_BASE_DELAY: cfg_reg.base_delay <= cfg_data[11:0];
                REG_SEPARATION: cfg_reg.separation <= cfg_data[11:0];
                REG_DEPTH:      cfg_reg.depth      <= cfg_data[10:0];
                REG_PHASE_STEP: phase_step_reg     <= cfg_data[31:0];
                default:
                begin
                end
            endcase
        end
    end

    scd_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .send_left  (send_left),
        .send_right (send_right),
        .dry_left   (dry_left),
        .dry_right  (dry_right),
        .frame_last (frame_last),
        .phase_step (phase_step_reg),
        .q_valid    (q_valid),
        .q_pop      (q_pop),
        .q_item     (q_item)
    );

    scd_back #(
        .RING_DEPTH (RING_DEPTH)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg_reg),
        .q_valid      (q_valid),
        .q_pop        (q_pop),
        .q_item       (q_item),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_left     (out_left),
        .out_right    (out_right),
        .end_of_block (end_of_block)
    );

endmodule

FILE: rtl/core/scd_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module scd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

FILE: rtl/core/scd_front.sv
// Front end: takes input requests, tags each with its oscillator phase and
// queues them for the back end. Depends on scd_pkg.
module scd_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic signed [31:0]  send_left,
    input  logic signed [31:0]  send_right,
    input  logic signed [31:0]  dry_left,
    input  logic signed [31:0]  dry_right,
    input  logic                frame_last,
    input  logic [31:0]         phase_step,
    output logic                q_valid,
    input  logic                q_pop,
    output scd_pkg::frame_t     q_item
);
    import scd_pkg::*;

    frame_t      entry_reg [2];
    logic        wr_ptr_reg;
    logic        rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [31:0] phase_reg;
    logic        push;
    logic        pop;

    assign in_stall = (count_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (count_reg != 2'd0);
    assign pop      = q_pop && q_valid;
    assign q_item   = entry_reg[rd_ptr_reg];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
            phase_reg  <= 32'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
                phase_reg  <= phase_reg + phase_step;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({push, pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= '{
                send_left:  send_left,
                send_right: send_right,
                dry_left:   dry_left,
                dry_right:  dry_right,
                frame_last: frame_last,
                phase:      phase_reg
            };
        end
    end

endmodule

FILE: rtl/core/scd_back.sv
// Back end: sine LFO, delay arithmetic, ring write and tap reads, output
// register. Depends on scd_pkg and scd_ram.
module scd_back #(
    parameter int RING_DEPTH = scd_pkg::RING_DEPTH_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  scd_pkg::delay_cfg_t cfg,
    input  logic                q_valid,
    output logic                q_pop,
    input  scd_pkg::frame_t     q_item,
    output logic                out_valid,
    input  logic                out_stall,
    output logic signed [31:0]  out_left,
    output logic signed [31:0]  out_right,
    output logic                end_of_block
);
    import scd_pkg::*;

    localparam int AW = $clog2(RING_DEPTH);
    localparam int DW = (AW + 2 > 15) ? AW + 2 : 15;
    localparam logic signed [DW-1:0] N_S   = DW'(RING_DEPTH);
    localparam logic [AW:0]          N_W   = (AW+1)'(RING_DEPTH);
    localparam logic [AW-1:0]        LAST  = AW'(RING_DEPTH - 1);

    back_state_t state_reg, state_next;

    frame_t                 item_reg;
    logic [31:0]            prod1_reg;
    logic signed [26:0]     prod2_reg;
    logic signed [DW-1:0]   delay_reg;
    logic signed [DW-1:0]   sep_reg;
    logic [AW-1:0]          r_idx_reg;
    logic [AW-1:0]          l_idx_reg;
    logic [AW-1:0]          wp_reg;
    logic                   filled_reg;
    logic                   out_valid_reg;
    logic signed [31:0]     out_left_reg;
    logic signed [31:0]     out_right_reg;
    logic                   eob_reg;

    logic [15:0]            t_val;
    logic [31:0]            v_val;
    logic signed [14:0]     v_sh;
    logic signed [11:0]     sine_part;
    logic                   delay_ok;
    logic                   sep_ok;
    logic [AW:0]            r_diff;
    logic [AW:0]            l_diff;
    logic                   out_free;
    logic                   ram_we;
    logic [31:0]            rd_left;
    logic [31:0]            rd_right;
    logic [31:0]            tap_left;
    logic [31:0]            tap_right;

    assign t_val     = item_reg.phase[30:15];
    assign v_val     = {prod1_reg[30:0], 1'b0} ^ {32{item_reg.phase[31]}};
    assign v_sh      = $signed(v_val[31:17]);
    assign sine_part = $signed(prod2_reg[26:15]);
    assign delay_ok  = !delay_reg[DW-1] && (delay_reg < N_S);
    assign sep_ok    = (sep_reg < N_S);
    assign r_diff    = {1'b0, wp_reg} - {1'b0, delay_reg[AW-1:0]};
    assign l_diff    = {1'b0, r_idx_reg} - {1'b0, sep_reg[AW-1:0]};
    assign out_free  = !out_valid_reg || !out_stall;
    assign ram_we    = (state_reg == BK_MUL1);
    assign q_pop     = (state_reg == BK_IDLE) && q_valid;

    assign out_valid    = out_valid_reg;
    assign out_left     = out_left_reg;
    assign out_right    = out_right_reg;
    assign end_of_block = eob_reg;

    scd_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ram_left (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (item_reg.send_left),
        .raddr (l_idx_reg),
        .rdata (rd_left)
    );

    scd_ram #(
        .WIDTH (32),
        .DEPTH (RING_DEPTH)
    ) u_ram_right (
        .clk   (clk),
        .we    (ram_we),
        .waddr (wp_reg),
        .wdata (item_reg.send_right),
        .raddr (r_idx_reg),
        .rdata (rd_right)
    );

    // entries never written since reset read as zero; the current slot was
    // written in BK_MUL1 but is forwarded anyway
    always_comb
    begin
        if (l_idx_reg == wp_reg)
        begin
            tap_left = item_reg.send_left;
        end
        else if (filled_reg || (l_idx_reg < wp_reg))
        begin
            tap_left = rd_left;
        end
        else
        begin
            tap_left = 32'd0;
        end
        if (r_idx_reg == wp_reg)
        begin
            tap_right = item_reg.send_right;
        end
        else if (filled_reg || (r_idx_reg < wp_reg))
        begin
            tap_right = rd_right;
        end
        else
        begin
            tap_right = 32'd0;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            BK_IDLE: if (q_valid) state_next = BK_MUL1;
            BK_MUL1: state_next = BK_MUL2;
            BK_MUL2: state_next = BK_SUM;
            BK_SUM:  state_next = BK_WRAP;
            BK_WRAP: if (delay_ok && sep_ok) state_next = BK_RIDX;
            BK_RIDX: state_next = BK_LIDX;
            BK_LIDX: state_next = BK_READ;
            BK_READ: state_next = BK_OUT;
            BK_OUT:  if (out_free) state_next = BK_IDLE;
            default: state_next = BK_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            wp_reg        <= '0;
            filled_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == BK_OUT && out_free)
            begin
                out_valid_reg <= 1'b1;
                if (wp_reg == LAST)
                begin
                    wp_reg     <= '0;
                    filled_reg <= 1'b1;
                end
                else
                begin
                    wp_reg <= wp_reg + 1'b1;
                end
            end
            else if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        case (state_reg)
            BK_IDLE:
            begin
                item_reg <= q_item;
            end
            BK_MUL1:
            begin
                prod1_reg <= 32'(t_val * (t_val ^ 16'hFFFF));
            end
            BK_MUL2:
            begin
                prod2_reg <= 27'(v_sh * $signed({1'b0, cfg.depth}));
            end
            BK_SUM:
            begin
                delay_reg <= DW'(sine_part) + DW'(cfg.base_delay) + DW'(cfg.depth);
                sep_reg   <= DW'(cfg.separation);
            end
            BK_WRAP:
            begin
                // bring delay and separation into 0 .. RING_DEPTH-1
                if (delay_reg[DW-1])
                begin
                    delay_reg <= delay_reg + N_S;
                end
                else if (delay_reg >= N_S)
                begin
                    delay_reg <= delay_reg - N_S;
                end
                if (!sep_ok)
                begin
                    sep_reg <= sep_reg - N_S;
                end
            end
            BK_RIDX:
            begin
                r_idx_reg <= r_diff[AW] ? AW'(r_diff + N_W) : r_diff[AW-1:0];
            end
            BK_LIDX:
            begin
                l_idx_reg <= l_diff[AW] ? AW'(l_diff + N_W) : l_diff[AW-1:0];
            end
            BK_OUT:
            begin
                if (out_free)
                begin
                    out_left_reg  <= item_reg.dry_left + $signed(tap_left);
                    out_right_reg <= item_reg.dry_right + $signed(tap_right);
                    eob_reg       <= item_reg.frame_last;
                end
            end
            default:
            begin
            end
        endcase
    end

endmodule

FILE: sim/stereo_chorus_delay_top_tb.sv
// Self-checking testbench for stereo_chorus_delay_top: directed and random frames
// against a behavioral chorus predictor, with random idling on both channels.
// Depends on scd_pkg and the stereo_chorus_delay_top RTL.
module stereo_chorus_delay_top_tb;
    import scd_pkg::*;

    localparam int RING           = RING_DEPTH_DEF;
    localparam int DRAIN_CYCLES   = 40;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed {
        logic [31:0] left;
        logic [31:0] right;
        logic        last;
    } mix_result_t;

    logic                    clk;
    logic                    rst_n;
    logic                    in_valid;
    logic                    in_stall;
    logic signed [31:0]      send_left;
    logic signed [31:0]      send_right;
    logic signed [31:0]      dry_left;
    logic signed [31:0]      dry_right;
    logic                    frame_last;
    logic                    out_valid;
    logic                    out_stall = 1'b0;
    logic signed [31:0]      out_left;
    logic signed [31:0]      out_right;
    logic                    end_of_block;
    logic                    cfg_we;
    logic [CFG_IDX_W-1:0]    cfg_index;
    logic [CFG_DATA_W-1:0]   cfg_data;

    // chorus predictor state
    logic [63:0]  echo_ring [0:RING-1];
    logic [11:0]  wr_pos;
    logic [31:0]  osc_phase;
    logic [11:0]  set_base;
    logic [11:0]  set_sep;
    logic [10:0]  set_depth;
    logic [31:0]  set_step;

    mix_result_t  pending_mix[$];
    int           error_count = 0;
    int           result_count = 0;
    int           stall_left = 0;
    int           stuck_cycles = 0;
    bit           tx_quiet = 1'b0;
    bit           rx_quiet = 1'b0;

    stereo_chorus_delay_top u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .send_left    (send_left),
        .send_right   (send_right),
        .dry_left     (dry_left),
        .dry_right    (dry_right),
        .frame_last   (frame_last),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_left     (out_left),
        .out_right    (out_right),
        .end_of_block (end_of_block),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    task automatic report_mismatch(input string msg);
        $display("ERROR result %0d: %s", result_count, msg);
        error_count++;
    endtask

    // parabolic sine of the oscillator phase, read as signed 32 bits
    function automatic longint lfo_sine(input logic [31:0] x);
        logic [15:0]        t;
        logic [31:0]        p;
        logic signed [31:0] v;
        t = x[30:15];
        p = {16'h0, t} * {16'h0, t ^ 16'hffff};
        p = p << 1;
        if (x[31])
            p = ~p;
        v = p;
        return v;
    endfunction

    // write-before-read, then both taps behind the write position
    task automatic predict_mix(input logic [31:0] sl, input logic [31:0] sr,
                               input logic [31:0] dl, input logic [31:0] dr,
                               input logic fl);
        longint      sine_part;
        longint      delay;
        longint      d;
        logic [11:0] r_idx;
        logic [11:0] l_idx;
        mix_result_t r;
        echo_ring[wr_pos] = {sr, sl};
        sine_part = ((lfo_sine(osc_phase) >>> 17) * longint'(set_depth)) >>> 15;
        delay = sine_part + longint'(set_base) + longint'(set_depth);
        d = delay % RING;
        if (d < 0)
            d = d + RING;
        r_idx = wr_pos - d[11:0];
        l_idx = r_idx - set_sep;
        r.left  = dl + echo_ring[l_idx][31:0];
        r.right = dr + echo_ring[r_idx][63:32];
        r.last  = fl;
        pending_mix.push_back(r);
        wr_pos    = wr_pos + 12'd1;
        osc_phase = osc_phase + set_step;
    endtask

    // one frame request; valid stays high across back-to-back requests
    task automatic send_frame(input logic [31:0] sl, input logic [31:0] sr,
                              input logic [31:0] dl, input logic [31:0] dr,
                              input logic fl);
        int gap;
        gap = tx_quiet ? 0 : $urandom_range(0, 14);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid   <= 1'b1;
        send_left  <= sl;
        send_right <= sr;
        dry_left   <= dl;
        dry_right  <= dr;
        frame_last <= fl;
        do @(posedge clk); while (in_stall);
        predict_mix(sl, sr, dl, dr, fl);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
        logic [31:0] junk;
        junk = $urandom();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        case (idx)
            REG_BASE_DELAY:
            begin
                cfg_data <= {junk[31:12], value[11:0]};
                set_base = value[11:0];
            end
            REG_SEPARATION:
            begin
                cfg_data <= {junk[31:12], value[11:0]};
                set_sep = value[11:0];
            end
            REG_DEPTH:
            begin
                cfg_data <= {junk[31:11], value[10:0]};
                set_depth = value[10:0];
            end
            default:
            begin
                cfg_data <= value;
                set_step = value;
            end
        endcase
        @(posedge clk);
    endtask

    task automatic program_chorus(input logic [11:0] base, input logic [11:0] sep,
                                  input logic [10:0] dep, input logic [31:0] step);
        write_reg(REG_DEPTH, {21'd0, dep});
        write_reg(REG_PHASE_STEP, step);
        write_reg(REG_SEPARATION, {20'd0, sep});
        write_reg(REG_BASE_DELAY, {20'd0, base});
        cfg_we <= 1'b0;
    endtask

    // sender holds off until every pending result is back
    task automatic drain_results();
        in_valid <= 1'b0;
        while (pending_mix.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // zero delay: each tap returns the send sample of the same frame
    task automatic test_write_before_read();
        program_chorus(12'd0, 12'd0, 11'd0, 32'd0);
        send_frame(32'h7fffffff, 32'h80000000, 32'h7fffffff, 32'h80000000, 1'b0);
        send_frame(32'h80000000, 32'h7fffffff, 32'hffffffff, 32'h00000001, 1'b1);
        send_frame(32'hffffffff, 32'hffffffff, 32'h00000000, 32'h00000000, 1'b0);
        send_frame(32'h00000000, 32'h00000000, 32'hffffffff, 32'hffffffff, 1'b1);
        send_frame(32'h55555555, 32'haaaaaaaa, 32'haaaaaaaa, 32'h55555555, 1'b0);
        send_frame(32'haaaaaaaa, 32'h55555555, 32'h12345678, 32'h87654321, 1'b1);
        drain_results();
    endtask

    // maximum registers: delay beyond ring depth, full swing of the sine
    task automatic test_extreme_delay();
        program_chorus(12'hfff, 12'hfff, 11'h7ff, 32'h2000_0000);
        for (int i = 0; i < 10; i++)
            send_frame($urandom(), $urandom(), $urandom(), $urandom(), i[0]);
        drain_results();
    endtask

    // fixed delay, left tap trailing the right one
    task automatic test_tap_separation();
        program_chorus(12'd3, 12'd2, 11'd0, 32'd0);
        for (int i = 0; i < 8; i++)
            send_frame(32'h1000 + i, 32'h2000 + i, 32'hffff_0000, 32'h0000_ffff, i == 7);
        drain_results();
    endtask

    task automatic random_frames(input int count);
        int block_left;
        block_left = $urandom_range(1, 16);
        for (int i = 0; i < count; i++)
        begin
            if (i % 40 == 0)
            begin
                tx_quiet = ($urandom_range(0, 3) == 0);
                rx_quiet = ($urandom_range(0, 3) == 0);
            end
            block_left--;
            send_frame($urandom(), $urandom(), $urandom(), $urandom(), block_left == 0);
            if (block_left == 0)
                block_left = $urandom_range(1, 16);
        end
    endtask

    task automatic test_random_settings();
        for (int s = 0; s < 6; s++)
        begin
            case (s)
                0: program_chorus(12'($urandom()), 12'($urandom()), 11'($urandom()),
                                  $urandom());
                1: program_chorus(12'hfff, 12'hfff, 11'h7ff, 32'hffff_ffff);
                2: program_chorus(12'd0, 12'd0, 11'h7ff, $urandom_range(0, 32'h0400_0000));
                3: program_chorus(12'hfff, 12'd0, 11'd0, 32'd0);
                4: program_chorus(12'($urandom_range(0, 64)), 12'($urandom()),
                                  11'($urandom()), $urandom());
                default: program_chorus(12'($urandom()), 12'($urandom_range(0, 16)),
                                        11'($urandom()), $urandom_range(0, 32'h0100_0000));
            endcase
            random_frames(85);
            drain_results();
        end
    endtask

    // long delays so the taps reach back past index zero of the ring
    task automatic test_ring_wrap();
        program_chorus(12'($urandom_range(2048, 4095)), 12'($urandom()), 11'($urandom()),
                       $urandom_range(0, 32'h0080_0000));
        random_frames(60);
        drain_results();
    endtask

    // output side: random stall after each result, then the check
    always @(posedge clk or negedge rst_n)
    begin : result_check
        int          hold;
        mix_result_t want;
        if (!rst_n)
        begin
            out_stall  <= 1'b0;
            stall_left <= 0;
        end
        else if (out_valid && !out_stall)
        begin
            hold = rx_quiet ? 0 : $urandom_range(0, 14);
            stall_left <= hold;
            out_stall  <= (hold != 0);
            result_count++;
            if (pending_mix.size() == 0)
                report_mismatch("result with no frame pending");
            else
            begin
                want = pending_mix.pop_front();
                if (out_left !== want.left)
                    report_mismatch($sformatf("out_left %h, want %h", out_left, want.left));
                if (out_right !== want.right)
                    report_mismatch($sformatf("out_right %h, want %h", out_right, want.right));
                if (end_of_block !== want.last)
                    report_mismatch($sformatf("end_of_block %b, want %b",
                                              end_of_block, want.last));
            end
        end
        else if (stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            out_stall  <= (stall_left != 1);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
            stuck_cycles <= 0;
        else
        begin
            stuck_cycles <= stuck_cycles + 1;
            if (stuck_cycles == WATCHDOG_LIMIT)
            begin
                $display("Testbench completed WITH ERRORS");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        send_left  = '0;
        send_right = '0;
        dry_left   = '0;
        dry_right  = '0;
        frame_last = 1'b0;
        cfg_we     = 1'b0;
        cfg_index  = REG_BASE_DELAY;
        cfg_data   = '0;
        for (int i = 0; i < RING; i++)
            echo_ring[i] = 64'd0;
        wr_pos    = '0;
        osc_phase = '0;
        set_base  = '0;
        set_sep   = '0;
        set_depth = '0;
        set_step  = '0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_write_before_read();
        test_extreme_delay();
        test_tap_separation();
        test_random_settings();
        test_ring_wrap();

        if (error_count == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

FILE: stereo_chorus_delay_top.f
rtl/core/scd_pkg.sv
rtl/core/scd_ram.sv
rtl/core/scd_front.sv
rtl/core/scd_back.sv
rtl/core/stereo_chorus_delay_top.sv
sim/stereo_chorus_delay_top_tb.sv
